// ===== src/hmns_pkg.sv =====
// Shared types and constants for the height map normal stencil.
package hmns_pkg;

   localparam int MAX_WIDTH_DEFAULT = 256;
   localparam int ROWS_KEPT         = 3;
   localparam int HEIGHT_LIMIT      = 4096;
   localparam int ONE_Q14           = 16384;
   localparam int WIDTH_RESET       = 256;
   localparam int HEIGHT_RESET      = 256;
   localparam int CSR_DATA_W        = 13;
   localparam int CSR_INDEX_W       = 1;
   localparam int MUL_A_W           = 32;
   localparam int MUL_B_W           = 18;
   localparam int SEARCH_TOP_BIT    = 14;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WIDTH  = 1'b0,
      CSR_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_DIFF,
      ST_SQR,
      ST_SQR_ACC,
      ST_BIT_SQ,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_CMP,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic               action;
      logic signed [15:0] height;
   } req_type;

   typedef struct packed {
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
      logic               degenerate;
      logic               last_of_frame;
   } rsp_type;

endpackage

// ===== src/height_map_normal_stencil.sv =====
// From request to result: store reads, the difference, squaring of each component, then
// the bit steps (ST_BIT_SQ, ST_MUL_LO, ST_MUL_HI, ST_CMP) for 15 bits of each of 3
// components; degenerate maps go straight to ST_OUT. One request in flight, held while the
// result side stalls; requests with no normal stay in ST_IDLE. The multiplier is shared.
// Reset (synchronous, active high) clears counters, phase and handshakes; width and height
// return to 256. The line store is not cleared: every entry is written before it is read.
module height_map_normal_stencil
   import hmns_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int DEPTH = ROWS_KEPT * MAX_WIDTH;
   localparam int AW    = $clog2(DEPTH);

   // configuration and frame position
   logic [8:0]    width_ff;
   logic [12:0]   height_ff;
   logic [CW-1:0] col_ff;
   logic [11:0]   row_ff;
   logic [CW-1:0] drain_col_ff;
   logic          drain_phase_ff;
   logic [1:0]    slot_ff;

   // sequencer and datapath
   state_type          state_ff, state_in;
   logic [AW-1:0]      addr_ff [0:3];
   logic signed [15:0] smp_ff [0:3];
   logic [2:0]         rd_cnt_ff;
   logic               sz2_ff, sx2_ff, last_ff, degen_ff;
   logic [16:0]        mag_ff [0:2];
   logic               neg_ff [0:2];
   logic [33:0]        n2_ff [0:2];
   logic [35:0]        s_ff;
   logic [1:0]         comp_ff;
   logic [14:0]        k_ff;
   logic [3:0]         bit_ff;
   logic [31:0]        asq_ff;
   logic [49:0]        plo_ff;
   logic [49:0]        prod_ff;
   logic signed [15:0] res_ff [0:2];
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   // line store
   logic signed [15:0] mem [0:DEPTH-1];
   logic signed [15:0] mem_q_ff;
   logic [AW-1:0]      rd_addr;

   logic [WW-1:0]  w_eff;
   logic [12:0]    h_eff;
   logic           req_accept, push_ok, drain_ok, emits, degen;
   logic           col_last, row_last, drain_last, out_free;
   logic [1:0]     slot_prev, slot_prev2, slot_mid, slot_up;
   logic [CW-1:0]  op_col, col_right, col_left;
   logic           op_sx2;
   logic [2:0]     rd_prev;
   logic [14:0]    t_cur;
   logic [15:0]    tm1;
   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [67:0]    cmp_total;
   logic [67:0]    cmp_bound;
   logic           cmp_ok;
   logic [14:0]    k_next;
   logic signed [16:0] dx, dz;
   logic [15:0]    adx, adz;

   function automatic logic [AW-1:0] slot_addr(input logic [1:0] slot,
                                                input logic [CW-1:0] col);
      logic [AW-1:0] base;
      case (slot)
         2'd1:    base = AW'(MAX_WIDTH);
         2'd2:    base = AW'(2 * MAX_WIDTH);
         default: base = '0;
      endcase
      return base + AW'(col);
   endfunction

   // Clamp the registers to the supported range.
   always_comb begin
      if (width_ff == 9'd0) begin
         w_eff = WW'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(width_ff);
      end
      if (height_ff == 13'd0) begin
         h_eff = 13'd1;
      end else if (height_ff > 13'(HEIGHT_LIMIT)) begin
         h_eff = 13'(HEIGHT_LIMIT);
      end else begin
         h_eff = height_ff;
      end
   end

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign push_ok    = !req_data.action && !drain_phase_ff;
   assign drain_ok   = req_data.action && drain_phase_ff;
   // A push of the first row only fills the store.
   assign emits      = (push_ok && row_ff != 12'd0) || drain_ok;
   assign degen      = (w_eff == WW'(1)) || (h_eff == 13'd1);
   assign col_last   = (WW'(col_ff) == w_eff - WW'(1));
   assign row_last   = (13'(row_ff) == h_eff - 13'd1);
   assign drain_last = (WW'(drain_col_ff) == w_eff - WW'(1));
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // Row slots rotate modulo three; slot_ff holds the row being pushed.
   always_comb begin
      case (slot_ff)
         2'd0:    begin slot_prev = 2'd2; slot_prev2 = 2'd1; end
         2'd1:    begin slot_prev = 2'd0; slot_prev2 = 2'd2; end
         default: begin slot_prev = 2'd1; slot_prev2 = 2'd0; end
      endcase
   end

   // Pick the rows and columns of the stencil for the normal to emit.
   // Pushing row r emits row r-1; a drain emits the last row with a
   // one-sided vertical difference.
   always_comb begin
      op_col = req_data.action ? drain_col_ff : col_ff;
      if (!req_data.action) begin
         slot_mid = slot_prev;
         slot_up  = (row_ff == 12'd1) ? slot_prev : slot_prev2;
      end else begin
         slot_mid = slot_ff;
         slot_up  = slot_prev;
      end
      if (op_col == '0) begin
         col_right = CW'(1);
         col_left  = '0;
         op_sx2    = 1'b0;
      end else if (WW'(op_col) == w_eff - WW'(1)) begin
         col_right = op_col;
         col_left  = op_col - CW'(1);
         op_sx2    = 1'b0;
      end else begin
         col_right = op_col + CW'(1);
         col_left  = op_col - CW'(1);
         op_sx2    = 1'b1;
      end
   end

   assign rd_addr = addr_ff[rd_cnt_ff[1:0]];
   assign rd_prev = rd_cnt_ff - 3'd1;

   // Rounding search: t is the candidate, test (2t-1)^2 * s <= 2^30 * n^2.
   assign t_cur     = k_ff | (15'd1 << bit_ff);
   assign tm1       = {t_cur, 1'b0} - 16'd1;
   assign cmp_total = {prod_ff, 18'b0} + 68'(plo_ff);
   assign cmp_bound = 68'({n2_ff[comp_ff], 30'b0});
   assign cmp_ok    = (cmp_total <= cmp_bound);
   assign k_next    = cmp_ok ? t_cur : k_ff;

   assign dx  = 17'(smp_ff[2]) - 17'(smp_ff[3]);
   assign dz  = 17'(smp_ff[1]) - 17'(smp_ff[0]);
   assign adx = dx[16] ? 16'(-dx) : 16'(dx);
   assign adz = dz[16] ? 16'(-dz) : 16'(dz);

   // Shared multiplier operands.
   always_comb begin
      case (state_ff)
         ST_SQR: begin
            mul_a = MUL_A_W'(mag_ff[comp_ff]);
            mul_b = MUL_B_W'(mag_ff[comp_ff]);
         end
         ST_BIT_SQ: begin
            mul_a = MUL_A_W'(tm1);
            mul_b = MUL_B_W'(tm1);
         end
         ST_MUL_LO: begin
            mul_a = prod_ff[31:0];
            mul_b = s_ff[17:0];
         end
         ST_MUL_HI: begin
            mul_a = asq_ff;
            mul_b = s_ff[35:18];
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && emits) begin
               state_in = degen ? ST_OUT : ST_READ;
            end
         end
         ST_READ: begin
            if (rd_cnt_ff == 3'd4) begin
               state_in = ST_DIFF;
            end
         end
         ST_DIFF:    state_in = ST_SQR;
         ST_SQR:     state_in = ST_SQR_ACC;
         ST_SQR_ACC: state_in = (comp_ff == 2'd2) ? ST_BIT_SQ : ST_SQR;
         ST_BIT_SQ:  state_in = ST_MUL_LO;
         ST_MUL_LO:  state_in = ST_MUL_HI;
         ST_MUL_HI:  state_in = ST_CMP;
         ST_CMP: begin
            if (bit_ff == 4'd0 && comp_ff == 2'd2) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_BIT_SQ;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Line store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_accept && push_ok) begin
         mem[slot_addr(slot_ff, col_ff)] <= req_data.height;
      end
      mem_q_ff <= mem[rd_addr];
   end

   // Frame position and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff       <= 9'(WIDTH_RESET);
         height_ff      <= 13'(HEIGHT_RESET);
         col_ff         <= '0;
         row_ff         <= '0;
         drain_col_ff   <= '0;
         drain_phase_ff <= 1'b0;
         slot_ff        <= 2'd0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_WIDTH:  width_ff  <= csr_write_data[8:0];
            CSR_HEIGHT: height_ff <= csr_write_data;
            default:    width_ff  <= width_ff;
         endcase
         // restart the frame on any write
         col_ff         <= '0;
         row_ff         <= '0;
         drain_col_ff   <= '0;
         drain_phase_ff <= 1'b0;
         slot_ff        <= 2'd0;
      end else if (state_ff == ST_IDLE && req_accept) begin
         if (push_ok) begin
            if (col_last) begin
               col_ff <= '0;
               if (row_last) begin
                  drain_phase_ff <= 1'b1;
                  drain_col_ff   <= '0;
               end else begin
                  row_ff  <= row_ff + 12'd1;
                  slot_ff <= (slot_ff == 2'd2) ? 2'd0 : slot_ff + 2'd1;
               end
            end else begin
               col_ff <= col_ff + CW'(1);
            end
         end else if (drain_ok) begin
            if (drain_last) begin
               col_ff         <= '0;
               row_ff         <= '0;
               drain_col_ff   <= '0;
               drain_phase_ff <= 1'b0;
               slot_ff        <= 2'd0;
            end else begin
               drain_col_ff <= drain_col_ff + CW'(1);
            end
         end
      end
   end

   // Datapath.
   always_ff @(posedge clock) begin
      prod_ff <= 50'(mul_a) * 50'(mul_b);
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && emits) begin
               addr_ff[0] <= slot_addr(slot_up, op_col);
               addr_ff[1] <= slot_addr(slot_ff, op_col);
               addr_ff[2] <= slot_addr(slot_mid, col_right);
               addr_ff[3] <= slot_addr(slot_mid, col_left);
               sz2_ff     <= !req_data.action && (row_ff != 12'd1);
               sx2_ff     <= op_sx2;
               last_ff    <= req_data.action && drain_last;
               degen_ff   <= degen;
               rd_cnt_ff  <= 3'd0;
               res_ff[0]  <= '0;
               res_ff[1]  <= 16'(ONE_Q14);
               res_ff[2]  <= '0;
            end
         end
         ST_READ: begin
            if (rd_cnt_ff != 3'd0) begin
               smp_ff[rd_prev[1:0]] <= mem_q_ff;
            end
            rd_cnt_ff <= rd_cnt_ff + 3'd1;
         end
         ST_DIFF: begin
            // nx = -sz*dx, ny = sz*sx*256, nz = -sx*dz
            mag_ff[0] <= sz2_ff ? {adx, 1'b0} : 17'(adx);
            neg_ff[0] <= !dx[16] && (dx != '0);
            mag_ff[1] <= 17'(256) << (32'(sz2_ff) + 32'(sx2_ff));
            neg_ff[1] <= 1'b0;
            mag_ff[2] <= sx2_ff ? {adz, 1'b0} : 17'(adz);
            neg_ff[2] <= !dz[16] && (dz != '0);
            s_ff      <= '0;
            comp_ff   <= 2'd0;
         end
         ST_SQR_ACC: begin
            n2_ff[comp_ff] <= prod_ff[33:0];
            s_ff           <= s_ff + 36'(prod_ff[33:0]);
            if (comp_ff == 2'd2) begin
               comp_ff <= 2'd0;
               k_ff    <= '0;
               bit_ff  <= 4'(SEARCH_TOP_BIT);
            end else begin
               comp_ff <= comp_ff + 2'd1;
            end
         end
         ST_MUL_LO: begin
            asq_ff <= prod_ff[31:0];
         end
         ST_MUL_HI: begin
            plo_ff <= prod_ff;
         end
         ST_CMP: begin
            if (bit_ff == 4'd0) begin
               res_ff[comp_ff] <= neg_ff[comp_ff] ? -16'(k_next) : 16'(k_next);
               comp_ff         <= comp_ff + 2'd1;
               k_ff            <= '0;
               bit_ff          <= 4'(SEARCH_TOP_BIT);
            end else begin
               k_ff   <= k_next;
               bit_ff <= bit_ff - 4'd1;
            end
         end
         default: begin
            rd_cnt_ff <= rd_cnt_ff;
         end
      endcase
   end

   // Output register: hold the result until taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_OUT && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT && out_free) begin
         rsp_data_ff.normal_x      <= res_ff[0];
         rsp_data_ff.normal_y      <= res_ff[1];
         rsp_data_ff.normal_z      <= res_ff[2];
         rsp_data_ff.degenerate    <= degen_ff;
         rsp_data_ff.last_of_frame <= last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_drain_col_zero: assert property (@(posedge clock) disable iff (reset)
      drain_phase_ff |-> (col_ff == '0))
      else $error("column count not cleared while draining");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      slot_ff != 2'd3)
      else $error("row slot out of range");

   a_search_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMP) |-> (k_ff <= 15'(ONE_Q14)))
      else $error("rounding search exceeded unit length");

   a_out_handoff: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && out_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("result not handed to output register");
`endif

endmodule
